// ===== sv/pmga_pkg.sv =====
package pmga_pkg;

	localparam int MAX_ATT   = 16;
	localparam int FRAC_BITS = 8;
	localparam int IDX_W     = $clog2(MAX_ATT);
	localparam int CNT_W     = $clog2(MAX_ATT + 1);

	localparam int POS_W = 32;
	localparam int STR_W = 48;
	localparam int D_W   = POS_W + 1;
	localparam int S_W   = 2 * D_W;
	localparam int R_W   = S_W / 2;
	localparam int SR_W  = R_W + 3;
	localparam int MA_W  = S_W;
	localparam int MB_W  = R_W;
	localparam int P_W   = MA_W + MB_W;
	localparam int NUM_W = STR_W + D_W + 2 * FRAC_BITS;
	localparam int LIM_W = 32 + 2 * FRAC_BITS;
	localparam int QC_W  = POS_W + 1;
	localparam int NCOMP = 3;

	localparam int MUL_STEPS  = MB_W;
	localparam int SQRT_STEPS = R_W;
	localparam int DIV_STEPS  = NUM_W;
	localparam int STEP_W     = $clog2(NUM_W);

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_AIU = 1'b0;
	localparam logic REG_MDS = 1'b1;

	localparam logic [1:0] COMP_FIRST = 2'd0;
	localparam logic [1:0] COMP_LAST  = 2'(NCOMP - 1);

	typedef struct packed {
		logic                    func;
		logic [3:0]              slot;
		logic signed [31:0]      pos_x;
		logic signed [31:0]      pos_y;
		logic signed [31:0]      pos_z;
		logic [47:0]             strength;
		logic signed [31:0]      accel_in_x;
		logic signed [31:0]      accel_in_y;
		logic signed [31:0]      accel_in_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] accel_out_x;
		logic signed [31:0] accel_out_y;
		logic signed [31:0] accel_out_z;
		logic               saturated;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIFF,
		ST_SQ_LD,
		ST_SQ_RUN,
		ST_SQ_ADD,
		ST_CHECK,
		ST_RT_LD,
		ST_RT_RUN,
		ST_DEN_LD,
		ST_DEN_RUN,
		ST_NUM_LD,
		ST_NUM_RUN,
		ST_DIV_LD,
		ST_DIV_RUN,
		ST_ACC,
		ST_NEXT,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_DEN,
		MUL_NUM
	} mul_sel_t;

	typedef struct packed {
		logic       start;
		logic       load;
		logic       diff;
		logic       mul_ld;
		mul_sel_t   mul_sel;
		logic       mul_run;
		logic       s_add;
		logic       rt_ld;
		logic       rt_run;
		logic       den_take;
		logic       div_ld;
		logic       div_run;
		logic       acc_add;
		logic       next;
		logic       out_load;
		logic [1:0] comp;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic last;
		logic skip;
		logic out_full;
	} status_t;

endpackage

// ===== sv/pmga_ctrl.sv =====
module pmga_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	input  pmga_pkg::status_t st,
	output pmga_pkg::cmd_t    cmd,
	output logic              busy
);
	import pmga_pkg::*;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic [1:0]        comp_q, comp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			comp_q  <= COMP_FIRST;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		comp_d  = comp_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_func == FUNC_QUERY) begin
					state_d = st.n_zero ? ST_FIN : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_DIFF;
			ST_DIFF: begin
				state_d = ST_SQ_LD;
				comp_d  = COMP_FIRST;
			end
			ST_SQ_LD: begin
				state_d = ST_SQ_RUN;
				cnt_d   = STEP_W'(MUL_STEPS - 1);
			end
			ST_SQ_RUN: begin
				if (cnt_q == '0) state_d = ST_SQ_ADD;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_SQ_ADD: begin
				if (comp_q == COMP_LAST) begin
					state_d = ST_CHECK;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = ST_SQ_LD;
				end
			end
			ST_CHECK: state_d = st.skip ? ST_NEXT : ST_RT_LD;
			ST_RT_LD: begin
				state_d = ST_RT_RUN;
				cnt_d   = STEP_W'(SQRT_STEPS - 1);
			end
			ST_RT_RUN: begin
				if (cnt_q == '0) state_d = ST_DEN_LD;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_DEN_LD: begin
				state_d = ST_DEN_RUN;
				cnt_d   = STEP_W'(MUL_STEPS - 1);
			end
			ST_DEN_RUN: begin
				if (cnt_q == '0) begin
					state_d = ST_NUM_LD;
					comp_d  = COMP_FIRST;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_NUM_LD: begin
				state_d = ST_NUM_RUN;
				cnt_d   = STEP_W'(MUL_STEPS - 1);
			end
			ST_NUM_RUN: begin
				if (cnt_q == '0) state_d = ST_DIV_LD;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_DIV_LD: begin
				state_d = ST_DIV_RUN;
				cnt_d   = STEP_W'(DIV_STEPS - 1);
			end
			ST_DIV_RUN: begin
				if (cnt_q == '0) state_d = ST_ACC;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_ACC: begin
				if (comp_q == COMP_LAST) begin
					state_d = ST_NEXT;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = ST_NUM_LD;
				end
			end
			ST_NEXT: state_d = st.last ? ST_FIN : ST_FETCH;
			ST_FIN: begin
				if (!st.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.comp = comp_q;
		busy     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.start = in_valid && in_func == FUNC_QUERY;
				cmd.load  = in_valid && in_func == FUNC_LOAD;
			end
			ST_DIFF:    cmd.diff = 1'b1;
			ST_SQ_LD: begin
				cmd.mul_ld  = 1'b1;
				cmd.mul_sel = MUL_SQ;
			end
			ST_SQ_RUN:  cmd.mul_run = 1'b1;
			ST_SQ_ADD:  cmd.s_add = 1'b1;
			ST_RT_LD:   cmd.rt_ld = 1'b1;
			ST_RT_RUN:  cmd.rt_run = 1'b1;
			ST_DEN_LD: begin
				cmd.mul_ld  = 1'b1;
				cmd.mul_sel = MUL_DEN;
			end
			ST_DEN_RUN: cmd.mul_run = 1'b1;
			ST_NUM_LD: begin
				cmd.mul_ld   = 1'b1;
				cmd.mul_sel  = MUL_NUM;
				cmd.den_take = comp_q == COMP_FIRST;
			end
			ST_NUM_RUN: cmd.mul_run = 1'b1;
			ST_DIV_LD:  cmd.div_ld = 1'b1;
			ST_DIV_RUN: cmd.div_run = 1'b1;
			ST_ACC:     cmd.acc_add = 1'b1;
			ST_NEXT:    cmd.next = 1'b1;
			ST_FIN:     cmd.out_load = !st.out_full;
			default:    cmd = '0;
		endcase
	end

endmodule

// ===== sv/pmga_dp.sv =====
module pmga_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pmga_pkg::cmd_t      cmd,
	output pmga_pkg::status_t   st,
	input  pmga_pkg::in_word_t  in_data,
	input  logic [4:0]          aiu,
	input  logic [31:0]         mds,
	output logic                out_valid,
	input  logic                out_stall,
	output pmga_pkg::out_word_t out_data
);
	import pmga_pkg::*;

	logic signed [POS_W-1:0] mem_x [MAX_ATT];
	logic signed [POS_W-1:0] mem_y [MAX_ATT];
	logic signed [POS_W-1:0] mem_z [MAX_ATT];
	logic [STR_W-1:0]        mem_s [MAX_ATT];

	logic signed [POS_W-1:0] rd_x_q, rd_y_q, rd_z_q;
	logic [STR_W-1:0]        rd_s_q;

	logic signed [POS_W-1:0] p_q   [NCOMP];
	logic signed [POS_W-1:0] acc_q [NCOMP];
	logic [D_W-1:0]          m_q   [NCOMP];
	logic [NCOMP-1:0]        neg_q;
	logic                    flag_q;
	logic [CNT_W-1:0]        n_q, idx_q, n_eff;
	logic [LIM_W-1:0]        lim_q;

	logic [S_W-1:0]   s_q;
	logic [P_W-1:0]   ma_q, mp_q, den_q;
	logic [MB_W-1:0]  mb_q;
	logic [S_W-1:0]   sqv_q;
	logic [R_W-1:0]   root_q;
	logic [SR_W-1:0]  srem_q;
	logic [NUM_W-1:0] nq_q;
	logic [P_W-1:0]   drem_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic signed [D_W-1:0] dx, dy, dz;
	logic [P_W-1:0]        mul_a;
	logic [MB_W-1:0]       mul_b;
	logic [SR_W-1:0]       rt_sh, rt_trial;
	logic [P_W:0]          dv_sh;
	logic                  q_big;
	logic [QC_W-1:0]       qc;
	logic signed [QC_W:0]  contrib;
	logic signed [QC_W+1:0] sum;
	logic                  ovf;
	logic signed [POS_W-1:0] acc_new;

	assign n_eff = (aiu > CNT_W'(MAX_ATT)) ? CNT_W'(MAX_ATT) : aiu;

	assign st.n_zero   = n_eff == '0;
	assign st.last     = CNT_W'(idx_q + 1'b1) == n_q;
	assign st.skip     = (s_q == '0) || (s_q < S_W'(lim_q));
	assign st.out_full = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// table write on load, registered read of the current slot every cycle
	always_ff @(posedge clk) begin
		if (cmd.load && CNT_W'(in_data.slot) < CNT_W'(MAX_ATT)) begin
			mem_x[in_data.slot[IDX_W-1:0]] <= in_data.pos_x;
			mem_y[in_data.slot[IDX_W-1:0]] <= in_data.pos_y;
			mem_z[in_data.slot[IDX_W-1:0]] <= in_data.pos_z;
			mem_s[in_data.slot[IDX_W-1:0]] <= in_data.strength;
		end
		rd_x_q <= mem_x[idx_q[IDX_W-1:0]];
		rd_y_q <= mem_y[idx_q[IDX_W-1:0]];
		rd_z_q <= mem_z[idx_q[IDX_W-1:0]];
		rd_s_q <= mem_s[idx_q[IDX_W-1:0]];
	end

	assign dx = D_W'(rd_x_q) - D_W'(p_q[0]);
	assign dy = D_W'(rd_y_q) - D_W'(p_q[1]);
	assign dz = D_W'(rd_z_q) - D_W'(p_q[2]);

	always_comb begin
		case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = P_W'(m_q[cmd.comp]);
				mul_b = MB_W'(m_q[cmd.comp]);
			end
			MUL_DEN: begin
				mul_a = P_W'(s_q);
				mul_b = MB_W'(root_q);
			end
			MUL_NUM: begin
				mul_a = P_W'(rd_s_q);
				mul_b = MB_W'(m_q[cmd.comp]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rt_sh    = {srem_q[SR_W-3:0], sqv_q[S_W-1 -: 2]};
	assign rt_trial = {1'b0, root_q, 2'b01};
	assign dv_sh    = {drem_q, nq_q[NUM_W-1]};

	assign q_big   = (|nq_q[NUM_W-1:QC_W]) || (nq_q[QC_W-1] && (|nq_q[QC_W-2:0]));
	assign qc      = q_big ? {1'b1, {(QC_W-1){1'b0}}} : nq_q[QC_W-1:0];
	assign contrib = neg_q[cmd.comp] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
	assign sum     = (QC_W+2)'(acc_q[cmd.comp]) + (QC_W+2)'(contrib);
	assign ovf     = !((sum[QC_W+1:POS_W-1] == '0) || (&sum[QC_W+1:POS_W-1]));
	assign acc_new = !ovf ? sum[POS_W-1:0] :
	                 sum[QC_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			p_q[0]   <= in_data.pos_x;
			p_q[1]   <= in_data.pos_y;
			p_q[2]   <= in_data.pos_z;
			acc_q[0] <= in_data.accel_in_x;
			acc_q[1] <= in_data.accel_in_y;
			acc_q[2] <= in_data.accel_in_z;
			n_q      <= n_eff;
			lim_q    <= LIM_W'(mds) << (2 * FRAC_BITS);
		end
		if (cmd.diff) begin
			m_q[0] <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
			m_q[1] <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
			m_q[2] <= dz[D_W-1] ? D_W'(-dz) : D_W'(dz);
			neg_q  <= {dz[D_W-1], dy[D_W-1], dx[D_W-1]};
			s_q    <= '0;
		end
		if (cmd.mul_ld) begin
			ma_q <= mul_a;
			mb_q <= mul_b;
			mp_q <= '0;
		end else if (cmd.mul_run) begin
			if (mb_q[0]) mp_q <= mp_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
		if (cmd.s_add) s_q <= s_q + S_W'(mp_q);
		if (cmd.rt_ld) begin
			sqv_q  <= s_q;
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.rt_run) begin
			sqv_q <= sqv_q << 2;
			if (rt_sh >= rt_trial) begin
				srem_q <= rt_sh - rt_trial;
				root_q <= {root_q[R_W-2:0], 1'b1};
			end else begin
				srem_q <= rt_sh;
				root_q <= {root_q[R_W-2:0], 1'b0};
			end
		end
		if (cmd.den_take) den_q <= mp_q;
		if (cmd.div_ld) begin
			nq_q   <= NUM_W'(mp_q) << (2 * FRAC_BITS);
			drem_q <= '0;
		end else if (cmd.div_run) begin
			if (dv_sh >= {1'b0, den_q}) begin
				drem_q <= P_W'(dv_sh - {1'b0, den_q});
				nq_q   <= {nq_q[NUM_W-2:0], 1'b1};
			end else begin
				drem_q <= dv_sh[P_W-1:0];
				nq_q   <= {nq_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.acc_add) acc_q[cmd.comp] <= acc_new;
		if (cmd.out_load) begin
			out_q.accel_out_x <= acc_q[0];
			out_q.accel_out_y <= acc_q[1];
			out_q.accel_out_z <= acc_q[2];
			out_q.saturated   <= flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q  <= '0;
				flag_q <= 1'b0;
			end else begin
				if (cmd.next) idx_q <= idx_q + 1'b1;
				if (cmd.acc_add && ovf) flag_q <= 1'b1;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/point_mass_gravity_accumulator_core.sv =====
// channel   direction  handshake                  word
// in        input      in_valid / in_stall        in_data  (pmga_pkg::in_word_t)
// out       output     out_valid / out_stall      out_data (pmga_pkg::out_word_t)
// cfg       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A load word is written while the sequencer stays idle. A query walks every attractor
// slot in use on the shared shift-add multiplier (33 steps), root unit (33 steps) and
// restoring divider (97 steps per axis); a skipped slot stops after its squares.
// Reset clears control and config; the attractor table holds garbage until loaded.
// in_stall stays high while a query is in flight; a finished word waits in the output
// register under out_stall and the next word can be taken meanwhile.
module point_mass_gravity_accumulator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pmga_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pmga_pkg::out_word_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import pmga_pkg::*;

	logic [4:0]  aiu_q;
	logic [31:0] mds_q;
	cmd_t        cmd;
	status_t     st;
	logic        busy;

	// config registers, word aligned; low address bits ignored
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MDS) ? mds_q : 32'(aiu_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aiu_q <= '0;
			mds_q <= 32'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_AIU: aiu_q <= pwdata[4:0];
				REG_MDS: mds_q <= pwdata;
				default: aiu_q <= aiu_q;
			endcase
		end
	end

	// hold the input side whenever the sequencer is not idle
	assign in_stall = busy;

	pmga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	pmga_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.aiu       (aiu_q),
		.mds       (mds_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a load word never leaves the block busy
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.func == FUNC_LOAD |=> !in_stall)
		else $error("load word left block busy");

	// a query word holds off further input
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.func == FUNC_QUERY |=> in_stall)
		else $error("query accepted but input not stalled");

	// a new result only follows query work
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a query in flight");

endmodule
